// ===== design/lpbrf_pkg.sv =====
package lpbrf_pkg;

    localparam int MODE_W         = 2;
    localparam int LEN_W          = 12;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 3;
    localparam int CFG_W          = 13;
    localparam int USED_W         = 13;
    localparam int MSGS_W         = 11;
    localparam int HDR_W          = 32;
    localparam int DEF_RING_BYTES = 4096;
    localparam int MIN_RING       = 8;
    localparam int HDR_BYTES      = 4;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CORRUPT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OOS      = 3'd4;

    typedef struct packed {
        logic                latch;
        logic                clear;
        logic                hdr_wr;
        logic                data_wr;
        logic                push_open_set;
        logic                push_commit;
        logic                rd_issue;
        logic                rd_from_head;
        logic                hdr_cap;
        logic [1:0]          byte_sel;
        logic                pop_begin;
        logic                pop_byte;
        logic                pop_commit;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_valid;
        logic                res_last;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              push_open;
        logic              pop_open;
        logic              no_space;
        logic              msg_zero;
        logic              used_lt4;
        logic              hdr_bad;
        logic              hdr_zero;
        logic              len_zero;
        logic              push_last;
        logic              pop_last;
    } flags_t;

endpackage

// ===== design/lpbrf_in_if.sv =====
interface lpbrf_in_if;
    import lpbrf_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  msg_length;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output mode, output msg_length, output data_byte,
                     input ready);
    modport sink   (input valid, input mode, input msg_length, input data_byte,
                     output ready);
endinterface

// ===== design/lpbrf_out_if.sv =====
interface lpbrf_out_if;
    import lpbrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_valid;
    logic                out_last;
    logic [LEN_W-1:0]    out_length;
    logic [USED_W-1:0]   used_bytes;
    logic [MSGS_W-1:0]   stored_messages;

    modport source (output valid, output status, output out_byte, output out_valid,
                     output out_last, output out_length, output used_bytes,
                     output stored_messages, input ready);
    modport sink   (input valid, input status, input out_byte, input out_valid,
                     input out_last, input out_length, input used_bytes,
                     input stored_messages, output ready);
endinterface

// ===== design/length_prefixed_byte_ring_fifo.sv =====
// Byte ring FIFO of length-prefixed messages. Each input word (push start, push data,
// pop, clear) yields exactly one result word, held in an output register so the next
// word is accepted while a result still waits. Words are handled one at a time through
// a single-port-write, registered-read byte memory: push data and clear finish in the
// dispatch step, a pop inside an open message reads one byte and then returns it, a
// push start writes four header bytes, and the first pop of a message reads four header
// bytes and checks the length, then reads the first data byte unless the message is
// empty or its header is bad. A refused push start, a push data word out of sequence
// and an empty-queue pop also finish in dispatch, which waits for the output register
// to be empty or read; the last step loads the result. Writing ring_size clamps it to
// 8..RING_BYTES and empties the queue; no clearing pass is needed after reset.
module length_prefixed_byte_ring_fifo #(
    parameter int RING_BYTES = lpbrf_pkg::DEF_RING_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lpbrf_pkg::CFG_W-1:0] cfg_wdata,
    lpbrf_in_if.sink                    in_ch,
    lpbrf_out_if.source                 out_ch
);
    import lpbrf_pkg::*;

    cmd_t   cmd;
    flags_t flags;
    logic   in_ready;
    logic   out_full;

    lpbrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_ready (out_ch.ready),
        .out_full  (out_full),
        .flags     (flags),
        .cmd       (cmd)
    );

    lpbrf_datapath #(
        .RING_BYTES (RING_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_mode       (in_ch.mode),
        .in_msg_length (in_ch.msg_length),
        .in_data_byte  (in_ch.data_byte),
        .cmd           (cmd),
        .flags         (flags),
        .res_status    (out_ch.status),
        .res_byte      (out_ch.out_byte),
        .res_valid     (out_ch.out_valid),
        .res_last      (out_ch.out_last),
        .res_length    (out_ch.out_length),
        .res_used      (out_ch.used_bytes),
        .res_msgs      (out_ch.stored_messages)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_full;

endmodule

// ===== design/lpbrf_ctrl.sv =====
module lpbrf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_full,
    input  lpbrf_pkg::flags_t flags,
    output lpbrf_pkg::cmd_t   cmd
);
    import lpbrf_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_HDRW     = 3'd2;
    localparam logic [2:0] S_HRD      = 3'd3;
    localparam logic [2:0] S_HLAST    = 3'd4;
    localparam logic [2:0] S_HEVAL    = 3'd5;
    localparam logic [2:0] S_PBYTE    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       full_reg, full_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!full_reg || out_ready)
                begin
                    state_next = S_IDLE;
                    case (flags.mode)
                        MODE_START:
                        begin
                            if (flags.push_open)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_OOS;
                            end
                            else if (flags.no_space)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_NO_SPACE;
                            end
                            else
                            begin
                                cmd.hdr_wr   = 1'b1;
                                cmd.byte_sel = 2'd0;
                                cnt_next     = 2'd1;
                                state_next   = S_HDRW;
                            end
                        end
                        MODE_DATA:
                        begin
                            cmd.res_load = 1'b1;
                            if (!flags.push_open)
                            begin
                                cmd.res_status = ST_OOS;
                            end
                            else
                            begin
                                cmd.res_status  = ST_OK;
                                cmd.data_wr     = 1'b1;
                                cmd.push_commit = flags.push_last;
                            end
                        end
                        MODE_POP:
                        begin
                            if (flags.pop_open)
                            begin
                                cmd.rd_issue = 1'b1;
                                state_next   = S_PBYTE;
                            end
                            else if (flags.msg_zero)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end
                            else if (flags.used_lt4)
                            begin
                                cmd.clear      = 1'b1;
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_CORRUPT;
                            end
                            else
                            begin
                                cmd.rd_issue     = 1'b1;
                                cmd.rd_from_head = 1'b1;
                                cnt_next         = 2'd1;
                                state_next       = S_HRD;
                            end
                        end
                        default:
                        begin
                            cmd.clear      = 1'b1;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_HDRW:
            begin
                cmd.hdr_wr   = 1'b1;
                cmd.byte_sel = cnt_reg;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    cmd.push_commit   = flags.len_zero;
                    cmd.push_open_set = !flags.len_zero;
                    cmd.res_load      = 1'b1;
                    cmd.res_status    = ST_OK;
                    state_next        = S_IDLE;
                end
            end
            S_HRD:
            begin
                cmd.rd_issue = 1'b1;
                cmd.hdr_cap  = 1'b1;
                cmd.byte_sel = cnt_reg - 2'd1;
                cnt_next     = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_HLAST;
                end
            end
            S_HLAST:
            begin
                cmd.hdr_cap  = 1'b1;
                cmd.byte_sel = 2'd3;
                state_next   = S_HEVAL;
            end
            S_HEVAL:
            begin
                if (flags.hdr_bad)
                begin
                    cmd.clear      = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_CORRUPT;
                    state_next     = S_IDLE;
                end
                else if (flags.hdr_zero)
                begin
                    cmd.pop_begin  = 1'b1;
                    cmd.pop_commit = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_last   = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.pop_begin = 1'b1;
                    cmd.rd_issue  = 1'b1;
                    state_next    = S_PBYTE;
                end
            end
            S_PBYTE:
            begin
                cmd.pop_byte   = 1'b1;
                cmd.pop_commit = flags.pop_last;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_valid  = 1'b1;
                cmd.res_last   = flags.pop_last;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
        begin
            full_next = 1'b1;
        end
        else if (out_ready)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 2'd0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            full_reg  <= full_next;
        end
    end

    assign out_full = full_reg;

endmodule

// ===== design/lpbrf_datapath.sv =====
module lpbrf_datapath #(
    parameter int RING_BYTES = lpbrf_pkg::DEF_RING_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lpbrf_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [lpbrf_pkg::MODE_W-1:0]   in_mode,
    input  logic [lpbrf_pkg::LEN_W-1:0]    in_msg_length,
    input  logic [lpbrf_pkg::BYTE_W-1:0]   in_data_byte,
    input  lpbrf_pkg::cmd_t                cmd,
    output lpbrf_pkg::flags_t              flags,
    output logic [lpbrf_pkg::STATUS_W-1:0] res_status,
    output logic [lpbrf_pkg::BYTE_W-1:0]   res_byte,
    output logic                           res_valid,
    output logic                           res_last,
    output logic [lpbrf_pkg::LEN_W-1:0]    res_length,
    output logic [lpbrf_pkg::USED_W-1:0]   res_used,
    output logic [lpbrf_pkg::MSGS_W-1:0]   res_msgs
);
    import lpbrf_pkg::*;

    localparam int PW = $clog2(RING_BYTES);
    localparam int LW = $clog2(RING_BYTES + 1);
    localparam int MW = $clog2(RING_BYTES / HDR_BYTES + 1);
    localparam int CW = ((LW > LEN_W) ? LW : LEN_W) + 1;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [LW-1:0] lim);
        logic [LW:0] n;
        n = (LW+1)'(p) + (LW+1)'(1);
        return (n >= (LW+1)'(lim)) ? '0 : PW'(n);
    endfunction

    logic [BYTE_W-1:0] mem [RING_BYTES];

    logic [LW-1:0]     limit_reg, limit_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [PW-1:0]     wptr_reg, wptr_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     rptr_reg, rptr_next;
    logic [LW-1:0]     used_reg, used_next;
    logic [MW-1:0]     msgs_reg, msgs_next;
    logic [LEN_W-1:0]  push_left_reg, push_left_next;
    logic [LEN_W-1:0]  push_len_reg, push_len_next;
    logic [LW-1:0]     pop_left_reg, pop_left_next;
    logic [LW-1:0]     pop_len_reg, pop_len_next;
    logic              push_open_reg, push_open_next;
    logic              pop_open_reg, pop_open_next;

    logic [MODE_W-1:0] mode_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BYTE_W-1:0] dbyte_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [HDR_W-1:0]  hdr_reg;

    logic              clr;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [PW-1:0]     wptr_adv;
    logic [PW-1:0]     rd_addr;
    logic [LW-1:0]     hdr_len;
    logic [LW-1:0]     pop_len_eff;

    assign clr     = cmd.clear | cfg_we;
    assign wr_en   = cmd.hdr_wr | cmd.data_wr;
    assign wr_addr = (cmd.hdr_wr && cmd.byte_sel == 2'd0) ? tail_reg : wptr_reg;
    assign wptr_adv = adv(wr_addr, limit_reg);
    assign rd_addr = cmd.rd_from_head ? head_reg : rptr_reg;
    assign hdr_len = LW'(hdr_reg);
    assign pop_len_eff = cmd.pop_begin ? hdr_len : pop_len_reg;

    always_comb
    begin
        if (cmd.data_wr)
        begin
            wr_data = dbyte_reg;
        end
        else
        begin
            case (cmd.byte_sel)
                2'd0:    wr_data = len_reg[BYTE_W-1:0];
                2'd1:    wr_data = BYTE_W'(len_reg >> BYTE_W);
                default: wr_data = '0;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_we)
        begin
            if (cfg_wdata < CFG_W'(MIN_RING))
            begin
                limit_next = LW'(MIN_RING);
            end
            else if (32'(cfg_wdata) > 32'(RING_BYTES))
            begin
                limit_next = LW'(RING_BYTES);
            end
            else
            begin
                limit_next = LW'(cfg_wdata);
            end
        end
        else
        begin
            limit_next = limit_reg;
        end

        wptr_next      = wr_en ? wptr_adv : wptr_reg;
        tail_next      = cmd.push_commit ? wptr_next : tail_reg;
        rptr_next      = cmd.rd_issue ? adv(rd_addr, limit_reg) : rptr_reg;
        head_next      = cmd.pop_commit ? rptr_reg : head_reg;
        used_next      = used_reg;
        msgs_next      = msgs_reg;
        push_left_next = push_left_reg;
        push_len_next  = push_len_reg;
        push_open_next = push_open_reg;
        pop_left_next  = pop_left_reg;
        pop_len_next   = pop_len_reg;
        pop_open_next  = pop_open_reg;

        if (cmd.hdr_wr && cmd.byte_sel == 2'd0)
        begin
            push_left_next = len_reg;
            push_len_next  = len_reg;
        end
        if (cmd.data_wr)
        begin
            push_left_next = push_left_reg - LEN_W'(1);
        end
        if (cmd.push_open_set)
        begin
            push_open_next = 1'b1;
        end
        if (cmd.push_commit)
        begin
            used_next      = used_reg + LW'(push_len_reg) + LW'(HDR_BYTES);
            msgs_next      = msgs_reg + MW'(1);
            push_open_next = 1'b0;
            push_left_next = '0;
        end

        if (cmd.pop_begin)
        begin
            pop_len_next  = hdr_len;
            pop_left_next = hdr_len;
            pop_open_next = 1'b1;
        end
        if (cmd.pop_byte)
        begin
            pop_left_next = pop_left_reg - LW'(1);
        end
        if (cmd.pop_commit)
        begin
            used_next     = used_reg - (pop_len_eff + LW'(HDR_BYTES));
            msgs_next     = msgs_reg - MW'(1);
            pop_open_next = 1'b0;
            pop_left_next = '0;
        end

        if (clr)
        begin
            tail_next      = '0;
            wptr_next      = '0;
            head_next      = '0;
            rptr_next      = '0;
            used_next      = '0;
            msgs_next      = '0;
            push_left_next = '0;
            push_len_next  = '0;
            pop_left_next  = '0;
            pop_len_next   = '0;
            push_open_next = 1'b0;
            pop_open_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LW'(RING_BYTES);
            tail_reg      <= '0;
            wptr_reg      <= '0;
            head_reg      <= '0;
            rptr_reg      <= '0;
            used_reg      <= '0;
            msgs_reg      <= '0;
            push_left_reg <= '0;
            push_len_reg  <= '0;
            pop_left_reg  <= '0;
            pop_len_reg   <= '0;
            push_open_reg <= 1'b0;
            pop_open_reg  <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            tail_reg      <= tail_next;
            wptr_reg      <= wptr_next;
            head_reg      <= head_next;
            rptr_reg      <= rptr_next;
            used_reg      <= used_next;
            msgs_reg      <= msgs_next;
            push_left_reg <= push_left_next;
            push_len_reg  <= push_len_next;
            pop_left_reg  <= pop_left_next;
            pop_len_reg   <= pop_len_next;
            push_open_reg <= push_open_next;
            pop_open_reg  <= pop_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= in_mode;
            len_reg   <= in_msg_length;
            dbyte_reg <= in_data_byte;
        end
        if (cmd.hdr_cap)
        begin
            hdr_reg[BYTE_W*cmd.byte_sel +: BYTE_W] <= rd_data_reg;
        end
        if (cmd.res_load)
        begin
            res_status <= cmd.res_status;
            res_byte   <= cmd.res_valid ? rd_data_reg : '0;
            res_valid  <= cmd.res_valid;
            res_last   <= cmd.res_last;
            res_length <= cmd.res_valid ? LEN_W'(pop_len_reg) : '0;
            res_used   <= USED_W'(used_next);
            res_msgs   <= MSGS_W'(msgs_next);
        end
    end

    assign flags.mode      = mode_reg;
    assign flags.push_open = push_open_reg;
    assign flags.pop_open  = pop_open_reg;
    assign flags.no_space  = (CW'(limit_reg) - CW'(used_reg)) < (CW'(len_reg) + CW'(HDR_BYTES));
    assign flags.msg_zero  = (msgs_reg == '0);
    assign flags.used_lt4  = (used_reg < LW'(HDR_BYTES));
    assign flags.hdr_bad   = (33'(used_reg) < (33'(hdr_reg) + 33'(HDR_BYTES)));
    assign flags.hdr_zero  = (hdr_reg == '0);
    assign flags.len_zero  = (len_reg == '0);
    assign flags.push_last = (push_left_reg == LEN_W'(1));
    assign flags.pop_last  = (pop_left_reg == LW'(1));

endmodule

// ===== bench/lpbrf_checker.sv =====
module lpbrf_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lpbrf_pkg::CFG_W-1:0] cfg_wdata,
    lpbrf_in_if                         in_ch,
    lpbrf_out_if                        out_ch,
    output int                          mismatch_count,
    output int                          results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpbrf_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic                has_byte;
        logic                last;
        logic [LEN_W-1:0]    length;
        logic [USED_W-1:0]   used;
        logic [MSGS_W-1:0]   msgs;
    } fifo_result_t;

    logic [BYTE_W-1:0] ring_mem [DEF_RING_BYTES];
    logic [CFG_W-1:0]  ring_sz;
    logic [LEN_W-1:0]  tail_c;
    logic [LEN_W-1:0]  wr_ptr;
    logic [LEN_W-1:0]  head_c;
    logic [LEN_W-1:0]  rd_ptr;
    logic [USED_W-1:0] fill_bytes;
    logic [MSGS_W-1:0] msg_total;
    logic [LEN_W-1:0]  push_rem;
    logic [LEN_W-1:0]  push_len;
    logic [LEN_W-1:0]  pop_rem;
    logic [LEN_W-1:0]  pop_len;
    logic              push_busy;
    logic              pop_busy;
    fifo_result_t      expected_q[$];
    int                mismatches;
    int                checked;

    function automatic int ring_limit();
        if (ring_sz < CFG_W'(MIN_RING))
        begin
            return MIN_RING;
        end
        if (ring_sz > CFG_W'(DEF_RING_BYTES))
        begin
            return DEF_RING_BYTES;
        end
        return int'(ring_sz);
    endfunction

    function automatic logic [LEN_W-1:0] next_ptr(input logic [LEN_W-1:0] p);
        int n;
        n = int'(p) + 1;
        return (n >= ring_limit()) ? '0 : LEN_W'(n);
    endfunction

    function automatic void store_byte(input logic [BYTE_W-1:0] b);
        ring_mem[wr_ptr] = b;
        wr_ptr = next_ptr(wr_ptr);
    endfunction

    function automatic logic [BYTE_W-1:0] fetch_byte();
        logic [BYTE_W-1:0] b;
        b = ring_mem[rd_ptr];
        rd_ptr = next_ptr(rd_ptr);
        return b;
    endfunction

    function automatic void empty_queue();
        tail_c     = '0;
        wr_ptr     = '0;
        head_c     = '0;
        rd_ptr     = '0;
        fill_bytes = '0;
        msg_total  = '0;
        push_rem   = '0;
        push_len   = '0;
        pop_rem    = '0;
        pop_len    = '0;
        push_busy  = 1'b0;
        pop_busy   = 1'b0;
    endfunction

    function automatic void close_push();
        tail_c     = wr_ptr;
        fill_bytes = fill_bytes + USED_W'(HDR_BYTES) + push_len;
        msg_total  = msg_total + 1'b1;
        push_busy  = 1'b0;
        push_rem   = '0;
    endfunction

    function automatic void close_pop();
        head_c     = rd_ptr;
        fill_bytes = fill_bytes - USED_W'(HDR_BYTES) - pop_len;
        msg_total  = msg_total - 1'b1;
        pop_busy   = 1'b0;
        pop_rem    = '0;
    endfunction

    function automatic fifo_result_t predict_fifo_result(input logic [MODE_W-1:0] mode,
                                                         input logic [LEN_W-1:0]  len,
                                                         input logic [BYTE_W-1:0] dbyte);
        fifo_result_t r;
        logic [31:0]  hdr;
        longint       need;
        logic         go;
        r        = '0;
        r.status = ST_OK;
        case (mode)
            MODE_START:
            begin
                if (push_busy)
                begin
                    r.status = ST_OOS;
                end
                else if (ring_limit() - int'(fill_bytes) < HDR_BYTES + int'(len))
                begin
                    r.status = ST_NO_SPACE;
                end
                else
                begin
                    wr_ptr = tail_c;
                    store_byte(len[7:0]);
                    store_byte({4'b0, len[11:8]});
                    store_byte(8'h00);
                    store_byte(8'h00);
                    push_len  = len;
                    push_rem  = len;
                    push_busy = 1'b1;
                    if (len == '0)
                    begin
                        close_push();
                    end
                end
            end
            MODE_DATA:
            begin
                if (!push_busy)
                begin
                    r.status = ST_OOS;
                end
                else
                begin
                    store_byte(dbyte);
                    push_rem = push_rem - 1'b1;
                    if (push_rem == '0)
                    begin
                        close_push();
                    end
                end
            end
            MODE_POP:
            begin
                go = 1'b1;
                if (!pop_busy)
                begin
                    if (msg_total == '0)
                    begin
                        r.status = ST_EMPTY;
                        go       = 1'b0;
                    end
                    else if (fill_bytes < USED_W'(HDR_BYTES))
                    begin
                        empty_queue();
                        r.status = ST_CORRUPT;
                        go       = 1'b0;
                    end
                    else
                    begin
                        rd_ptr      = head_c;
                        hdr[7:0]    = fetch_byte();
                        hdr[15:8]   = fetch_byte();
                        hdr[23:16]  = fetch_byte();
                        hdr[31:24]  = fetch_byte();
                        need        = longint'(HDR_BYTES) + longint'(hdr);
                        if (longint'(fill_bytes) < need)
                        begin
                            empty_queue();
                            r.status = ST_CORRUPT;
                            go       = 1'b0;
                        end
                        else
                        begin
                            pop_len  = hdr[LEN_W-1:0];
                            pop_rem  = hdr[LEN_W-1:0];
                            pop_busy = 1'b1;
                            if (hdr == '0)
                            begin
                                r.last = 1'b1;
                                close_pop();
                                go     = 1'b0;
                            end
                        end
                    end
                end
                if (go)
                begin
                    r.length   = pop_len;
                    r.data     = fetch_byte();
                    r.has_byte = 1'b1;
                    pop_rem    = pop_rem - 1'b1;
                    if (pop_rem == '0)
                    begin
                        r.last = 1'b1;
                        close_pop();
                    end
                end
            end
            default:
            begin
                empty_queue();
            end
        endcase
        r.used = fill_bytes;
        r.msgs = msg_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        // hold the log to a readable size
        if (mismatches <= 200)
        begin
            $display("%0t ns: result %0d: %s", $realtime, checked, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t want;
        if (!rst_n)
        begin
            ring_sz = CFG_W'(DEF_RING_BYTES);
            empty_queue();
            expected_q.delete();
            mismatches = 0;
            checked    = 0;
            mismatch_count <= 0;
            results_owed   <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result word with no input word pending");
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", 16'(out_ch.status), 16'(want.status));
                    check_field("out_byte", 16'(out_ch.out_byte), 16'(want.data));
                    check_field("out_valid", 16'(out_ch.out_valid), 16'(want.has_byte));
                    check_field("out_last", 16'(out_ch.out_last), 16'(want.last));
                    check_field("out_length", 16'(out_ch.out_length), 16'(want.length));
                    check_field("used_bytes", 16'(out_ch.used_bytes), 16'(want.used));
                    check_field("stored_messages", 16'(out_ch.stored_messages),
                                16'(want.msgs));
                end
                checked++;
            end
            if (cfg_we)
            begin
                ring_sz = cfg_wdata;
                empty_queue();
            end
            if (in_ch.valid && in_ch.ready)
            begin
                expected_q.push_back(predict_fifo_result(in_ch.mode, in_ch.msg_length,
                                                         in_ch.data_byte));
            end
            mismatch_count <= mismatches;
            results_owed   <= expected_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpbrf_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               results_owed;
    bit               idle_on;
    int               stall_left;
    int               words_sent;
    int               ring_cap;
    int               ring_fill;
    int               pop_rest;
    int               pop_msg_len;
    int               queued_lengths[$];
    logic [CFG_W-1:0] ring_plan[7];

    lpbrf_in_if  in_ch ();
    lpbrf_out_if out_ch ();

    length_prefixed_byte_ring_fifo u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lpbrf_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (fail_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_left   <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] m, input int len_v, input int byte_v);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.msg_length <= LEN_W'(len_v);
        in_ch.data_byte  <= BYTE_W'(byte_v);
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic clear_all();
        send_word(MODE_CLEAR, $urandom, $urandom);
        queued_lengths.delete();
        ring_fill = 0;
        pop_rest  = 0;
    endtask

    task automatic pop_one();
        if (pop_rest == 0 && queued_lengths.size() > 0)
        begin
            pop_msg_len = queued_lengths.pop_front();
            pop_rest    = (pop_msg_len == 0) ? 1 : pop_msg_len;
        end
        send_word(MODE_POP, $urandom, $urandom);
        if (pop_rest > 0)
        begin
            pop_rest--;
            if (pop_rest == 0)
            begin
                ring_fill -= HDR_BYTES + pop_msg_len;
            end
        end
    endtask

    task automatic push_message(input int len_v);
        int r;
        send_word(MODE_START, len_v, $urandom);
        for (int i = 0; i < len_v; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                pop_one();
            end
            else if (r < 10)
            begin
                send_word(MODE_START, $urandom, $urandom);
            end
            send_word(MODE_DATA, $urandom, $urandom);
        end
        queued_lengths.push_back(len_v);
        ring_fill += HDR_BYTES + len_v;
    endtask

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int goal;
        int room;
        int r;
        int len_v;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_START;
        in_ch.msg_length = '0;
        in_ch.data_byte  = '0;
        out_ch.ready     = 1'b0;
        idle_on          = 1'b1;
        stall_left       = 0;
        words_sent       = 0;
        ring_fill        = 0;
        pop_rest         = 0;
        pop_msg_len      = 0;
        ring_plan = '{CFG_W'(0), CFG_W'(8191), CFG_W'(8), CFG_W'(4096),
                      CFG_W'($urandom_range(9, 40)), CFG_W'($urandom_range(41, 600)),
                      CFG_W'(24)};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_word(MODE_POP, 0, 0);
        send_word(MODE_DATA, 0, 8'hFF);
        send_word(MODE_START, 12'hFFF, 0);
        send_word(MODE_START, 0, 0);
        send_word(MODE_START, 3, 0);
        send_word(MODE_START, 1, 0);
        send_word(MODE_DATA, 0, 8'h00);
        send_word(MODE_DATA, 0, 8'hFF);
        send_word(MODE_DATA, 0, 8'h5A);
        send_word(MODE_POP, 0, 0);
        send_word(MODE_POP, 0, 0);
        send_word(MODE_POP, 0, 0);
        send_word(MODE_POP, 0, 0);
        send_word(MODE_POP, 0, 0);
        send_word(MODE_START, 2, 0);
        send_word(MODE_DATA, 0, 8'h81);
        send_word(MODE_CLEAR, 0, 0);
        send_word(MODE_DATA, 0, 8'h7E);
        send_word(MODE_POP, 0, 0);
        send_word(MODE_START, 4092, 0);
        send_word(MODE_CLEAR, 0, 0);
        send_word(MODE_START, 4093, 0);

        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            cfg_we    <= 1'b1;
            cfg_wdata <= ring_plan[ph];
            @(posedge clk);
            cfg_we    <= 1'b0;
            ring_cap = int'(ring_plan[ph]);
            if (ring_cap < MIN_RING)
            begin
                ring_cap = MIN_RING;
            end
            else if (ring_cap > DEF_RING_BYTES)
            begin
                ring_cap = DEF_RING_BYTES;
            end
            queued_lengths.delete();
            ring_fill = 0;
            pop_rest  = 0;
            idle_on  <= (ph != 3 && ph != 6);
            goal = words_sent + 118;
            while (words_sent < goal)
            begin
                room = ring_cap - ring_fill - HDR_BYTES;
                r    = $urandom_range(0, 99);
                if (r < 40 && room >= 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                    begin
                        len_v = $urandom_range(0, (room < 12) ? room : 12);
                    end
                    else if (r < 90)
                    begin
                        len_v = $urandom_range(0, (room < 64) ? room : 64);
                    end
                    else
                    begin
                        len_v = (room < 120) ? room : 120;
                    end
                    push_message(len_v);
                end
                else if (r < 82)
                begin
                    repeat ($urandom_range(1, 12)) pop_one();
                end
                else if (r < 88)
                begin
                    send_word(MODE_START, $urandom_range((room < 0) ? 0 : room + 1, 4095),
                              $urandom);
                end
                else if (r < 94)
                begin
                    send_word(MODE_DATA, $urandom, $urandom);
                end
                else if (r < 96)
                begin
                    clear_all();
                end
                else if (room >= 1)
                begin
                    // drop a message halfway through
                    len_v = $urandom_range(1, (room < 16) ? room : 16);
                    send_word(MODE_START, len_v, $urandom);
                    repeat ($urandom_range(0, len_v - 1))
                    begin
                        send_word(MODE_DATA, $urandom, $urandom);
                    end
                    clear_all();
                end
            end
        end

        drain();
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
